[rtl/mfa_pkg.sv]
package mfa_pkg;

  // field and storage widths
  localparam int DATA_W  = 32;
  localparam int SUM_W   = 40;
  localparam int CNT_W   = 8;
  localparam int CH_W    = 4;
  localparam int FLEN_W  = 8;
  localparam int MASK_W  = 16;
  localparam int CFG_IDX_W  = 8;
  localparam int CFG_DATA_W = 16;

  // register indexes on the configuration port
  localparam logic [CFG_IDX_W-1:0] CFG_FRAME_LENGTH = 8'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_ROUND_MASK   = 8'd1;

  // register reset values
  localparam logic [FLEN_W-1:0] FRAME_LEN_RST  = 8'd10;
  localparam logic [MASK_W-1:0] ROUND_MASK_RST = 16'h2000;

  // operation codes
  localparam logic OP_SAMPLE = 1'b0;
  localparam logic OP_TICK   = 1'b1;

  localparam logic [CNT_W-1:0]  CNT_MAX  = 8'hFF;
  localparam logic [FLEN_W-1:0] TICK_MAX = 8'hFF;

  // controller to datapath
  typedef struct packed {
    logic in_load;
    logic rd_en;
    logic rd_sweep;
    logic acc_wr;
    logic tick_upd;
    logic div_start;
    logic out_load;
    logic frame_clr;
    logic ch_inc;
  } cmd_t;

  // datapath to controller
  typedef struct packed {
    logic in_is_tick;
    logic frame_end;
    logic div_done;
    logic out_free;
    logic last_ch;
  } sts_t;

endpackage

[rtl/mfa_ram.sv]
module mfa_ram #(
  parameter int WIDTH = 48,
  parameter int DEPTH = 16
) (
  input  logic                                      clk,
  input  logic                                      we,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  logic [WIDTH-1:0]                          wdata,
  input  logic                                      re,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [WIDTH-1:0]                          rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  // one write port, one registered read port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

[rtl/mfa_div.sv]
module mfa_div (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              start,
  input  logic signed [mfa_pkg::SUM_W-1:0]  dividend,
  input  logic [mfa_pkg::CNT_W-1:0]         divisor,
  output logic                              done,
  output logic signed [mfa_pkg::DATA_W-1:0] quotient
);

  import mfa_pkg::*;

  localparam int STEP_W = $clog2(SUM_W);

  logic              busy_r;
  logic              fin_r;
  logic              done_r;
  logic [STEP_W-1:0] step_r;
  logic [CNT_W-1:0]  rem_r;
  logic [SUM_W-1:0]  quo_r;
  logic              neg_r;
  logic [DATA_W-1:0] q_res_r;

  logic [CNT_W:0]    shifted;
  logic [CNT_W:0]    diff;
  logic              ge;
  logic [CNT_W-1:0]  rem_nxt;
  logic [SUM_W-1:0]  quo_nxt;
  logic [SUM_W-1:0]  mag;
  logic              last_step;

  // restoring division on the magnitude, one quotient bit per cycle
  always_comb begin
    shifted   = {rem_r, quo_r[SUM_W-1]};
    diff      = shifted - {1'b0, divisor};
    ge        = (shifted >= {1'b0, divisor});
    rem_nxt   = ge ? diff[CNT_W-1:0] : shifted[CNT_W-1:0];
    quo_nxt   = {quo_r[SUM_W-2:0], ge};
    mag       = dividend[SUM_W-1] ? (~dividend + 1'b1) : dividend;
    last_step = (step_r == STEP_W'(SUM_W - 1));
  end

  // sequencing flags
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      fin_r  <= 1'b0;
      done_r <= 1'b0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
        fin_r  <= 1'b0;
      end else if (busy_r) begin
        if (last_step) begin
          busy_r <= 1'b0;
          fin_r  <= 1'b1;
        end
      end else if (fin_r) begin
        fin_r  <= 1'b0;
        done_r <= 1'b1;
      end
    end
  end

  // working registers; sign restored on the low word in the finishing cycle
  always_ff @(posedge clk) begin
    if (start) begin
      quo_r  <= mag;
      rem_r  <= '0;
      step_r <= '0;
      neg_r  <= dividend[SUM_W-1];
    end else if (busy_r) begin
      quo_r  <= quo_nxt;
      rem_r  <= rem_nxt;
      step_r <= step_r + 1'b1;
    end else if (fin_r) begin
      q_res_r <= neg_r ? (~quo_r[DATA_W-1:0] + 1'b1) : quo_r[DATA_W-1:0];
    end
  end

  assign done     = done_r;
  assign quotient = q_res_r;

endmodule

[rtl/mfa_dp.sv]
module mfa_dp #(
  parameter int NUM_CHANNELS = 16,
  parameter int FRAC_BITS    = 8
) (
  input  logic                                  clk,
  input  logic                                  rst_n,
  input  mfa_pkg::cmd_t                         cmd,
  output mfa_pkg::sts_t                         sts,
  input  logic                                  in_operation,
  input  logic [mfa_pkg::CH_W-1:0]              in_channel,
  input  logic signed [mfa_pkg::DATA_W-1:0]     in_sample_value,
  input  logic                                  cfg_valid,
  input  logic [mfa_pkg::CFG_IDX_W-1:0]         cfg_index,
  input  logic [mfa_pkg::CFG_DATA_W-1:0]        cfg_data,
  input  logic                                  out_ready,
  output logic                                  out_valid,
  output logic [mfa_pkg::CH_W-1:0]              out_channel,
  output logic signed [mfa_pkg::DATA_W-1:0]     out_average,
  output logic [mfa_pkg::CNT_W-1:0]             out_sample_count,
  output logic                                  out_has_value,
  output logic                                  out_last
);

  import mfa_pkg::*;

  localparam int AW    = (NUM_CHANNELS > 1) ? $clog2(NUM_CHANNELS) : 1;
  localparam int RAM_W = SUM_W + CNT_W;
  localparam logic [DATA_W:0]   RND_HALF = (33'd1 << FRAC_BITS) >> 1;
  localparam logic [DATA_W:0]   RND_MASK = ~((33'd1 << FRAC_BITS) - 33'd1);
  localparam logic [DATA_W-1:0] RND_SAT  = 32'h8000_0000 - (32'd1 << FRAC_BITS);

  // configuration
  logic [FLEN_W-1:0]       frame_len_r;
  logic [MASK_W-1:0]       round_mask_r;

  // frame state
  logic [FLEN_W-1:0]       tick_r;
  logic [NUM_CHANNELS-1:0] valid_r;
  logic [AW-1:0]           ch_r;
  logic [CNT_W-1:0]        cnt_cap_r;

  // latched input beat
  logic [CH_W-1:0]          chan_r;
  logic signed [DATA_W-1:0] val_r;

  // output register
  logic                     out_valid_r;
  logic [CH_W-1:0]          out_ch_r;
  logic signed [DATA_W-1:0] out_avg_r;
  logic [CNT_W-1:0]         out_cnt_r;
  logic                     out_has_r;
  logic                     out_last_r;

  logic                     chan_ok;
  logic [AW-1:0]            chan_idx;
  logic                     ent_valid;
  logic                     sweep_valid;
  logic [AW-1:0]            raddr;
  logic [RAM_W-1:0]         rdata;
  logic [SUM_W-1:0]         rd_sum;
  logic [CNT_W-1:0]         rd_cnt;
  logic [SUM_W-1:0]         cur_sum;
  logic [CNT_W-1:0]         cur_cnt;
  logic                     we;
  logic [RAM_W-1:0]         wdata;
  logic [FLEN_W-1:0]        tick_inc;
  logic signed [SUM_W-1:0]  div_dividend;
  logic                     div_done;
  logic signed [DATA_W-1:0] div_q;
  logic [DATA_W:0]          rnd_sum;
  logic [DATA_W:0]          rnd_val;
  logic [DATA_W-1:0]        rnd_res;
  logic [DATA_W-1:0]        avg_nxt;
  logic                     last_ch;

  // sample address decode
  always_comb begin
    chan_ok   = ({1'b0, chan_r} < (CH_W + 1)'(NUM_CHANNELS));
    chan_idx  = chan_r[AW-1:0];
    ent_valid = chan_ok && valid_r[chan_idx];
    sweep_valid = valid_r[ch_r];
    raddr     = cmd.rd_sweep ? ch_r : chan_idx;
    rd_sum    = rdata[RAM_W-1:CNT_W];
    rd_cnt    = rdata[CNT_W-1:0];
  end

  // accumulate: entries not yet written this frame read as empty
  always_comb begin
    cur_sum = ent_valid ? rd_sum : '0;
    cur_cnt = ent_valid ? rd_cnt : '0;
    we      = cmd.acc_wr && chan_ok && (cur_cnt != CNT_MAX);
    wdata   = {cur_sum + {{(SUM_W - DATA_W){val_r[DATA_W-1]}}, val_r},
               cur_cnt + 1'b1};
  end

  mfa_ram #(
    .WIDTH (RAM_W),
    .DEPTH (NUM_CHANNELS)
  ) u_ram (
    .clk   (clk),
    .we    (we),
    .waddr (chan_idx),
    .wdata (wdata),
    .re    (cmd.rd_en),
    .raddr (raddr),
    .rdata (rdata)
  );

  // shared divider for the frame-end sweep
  assign div_dividend = sweep_valid ? rd_sum : '0;

  mfa_div u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (cmd.div_start),
    .dividend (div_dividend),
    .divisor  (cnt_cap_r),
    .done     (div_done),
    .quotient (div_q)
  );

  // round half up to an integer, saturating at the top, for channels in the rounding mask
  always_comb begin
    rnd_sum = {div_q[DATA_W-1], div_q} + RND_HALF;
    rnd_val = rnd_sum & RND_MASK;
    rnd_res = (!rnd_val[DATA_W] && rnd_val[DATA_W-1]) ? RND_SAT : rnd_val[DATA_W-1:0];
    if (cnt_cap_r == '0) begin
      avg_nxt = '0;
    end else if (round_mask_r[ch_r]) begin
      avg_nxt = rnd_res;
    end else begin
      avg_nxt = div_q;
    end
  end

  // frame counter
  always_comb begin
    tick_inc = (tick_r == TICK_MAX) ? tick_r : tick_r + 1'b1;
    last_ch  = (ch_r == AW'(NUM_CHANNELS - 1));
  end

  // status
  always_comb begin
    sts.in_is_tick = (in_operation == OP_TICK);
    sts.frame_end  = (tick_inc >= frame_len_r);
    sts.div_done   = div_done;
    sts.out_free   = !out_valid_r || out_ready;
    sts.last_ch    = last_ch;
  end

  // control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      frame_len_r  <= FRAME_LEN_RST;
      round_mask_r <= ROUND_MASK_RST;
      tick_r       <= '0;
      valid_r      <= '0;
      ch_r         <= '0;
      out_valid_r  <= 1'b0;
    end else begin
      if (cfg_valid) begin
        unique case (cfg_index)
          CFG_FRAME_LENGTH: frame_len_r  <= cfg_data[FLEN_W-1:0];
          CFG_ROUND_MASK:   round_mask_r <= cfg_data[MASK_W-1:0];
          default: ;
        endcase
      end
      if (cmd.tick_upd) begin
        tick_r <= tick_inc;
      end
      if (we) begin
        valid_r[chan_idx] <= 1'b1;
      end
      if (cmd.ch_inc) begin
        ch_r <= ch_r + 1'b1;
      end
      if (cmd.frame_clr) begin
        tick_r  <= '0;
        valid_r <= '0;
        ch_r    <= '0;
      end
      if (cmd.out_load) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    if (cmd.in_load) begin
      chan_r <= in_channel;
      val_r  <= in_sample_value;
    end
    if (cmd.div_start) begin
      cnt_cap_r <= sweep_valid ? rd_cnt : '0;
    end
    if (cmd.out_load) begin
      out_ch_r   <= CH_W'(ch_r);
      out_avg_r  <= avg_nxt;
      out_cnt_r  <= cnt_cap_r;
      out_has_r  <= (cnt_cap_r != '0);
      out_last_r <= last_ch;
    end
  end

  assign out_valid        = out_valid_r;
  assign out_channel      = out_ch_r;
  assign out_average      = out_avg_r;
  assign out_sample_count = out_cnt_r;
  assign out_has_value    = out_has_r;
  assign out_last         = out_last_r;

endmodule

[rtl/mfa_ctrl.sv]
module mfa_ctrl (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          in_valid,
  output logic          in_ready,
  input  mfa_pkg::sts_t sts,
  output mfa_pkg::cmd_t cmd
);

  import mfa_pkg::*;

  typedef enum logic [7:0] {
    S_IDLE   = 8'b0000_0001,
    S_SRD    = 8'b0000_0010,
    S_SWR    = 8'b0000_0100,
    S_TICK   = 8'b0000_1000,
    S_RD     = 8'b0001_0000,
    S_DSTART = 8'b0010_0000,
    S_DWAIT  = 8'b0100_0000,
    S_OUT    = 8'b1000_0000
  } state_t;

  state_t state_r;
  state_t state_nxt;

  // next state and commands
  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    in_ready  = 1'b0;
    unique case (state_r)
      S_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.in_load = 1'b1;
          state_nxt   = sts.in_is_tick ? S_TICK : S_SRD;
        end
      end
      S_SRD: begin
        cmd.rd_en = 1'b1;
        state_nxt = S_SWR;
      end
      S_SWR: begin
        cmd.acc_wr = 1'b1;
        state_nxt  = S_IDLE;
      end
      S_TICK: begin
        cmd.tick_upd = 1'b1;
        state_nxt    = sts.frame_end ? S_RD : S_IDLE;
      end
      S_RD: begin
        cmd.rd_en    = 1'b1;
        cmd.rd_sweep = 1'b1;
        state_nxt    = S_DSTART;
      end
      S_DSTART: begin
        cmd.div_start = 1'b1;
        state_nxt     = S_DWAIT;
      end
      S_DWAIT: begin
        if (sts.div_done) begin
          state_nxt = S_OUT;
        end
      end
      S_OUT: begin
        if (sts.out_free) begin
          cmd.out_load = 1'b1;
          if (sts.last_ch) begin
            cmd.frame_clr = 1'b1;
            state_nxt     = S_IDLE;
          end else begin
            cmd.ch_inc = 1'b1;
            state_nxt  = S_RD;
          end
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

endmodule

[rtl/multichannel_frame_averager.sv]
// Per-channel frame averager.
// Input channel (in_valid/in_ready): one beat is either a sample for a
// channel (in_operation = 0) or a sampling tick (in_operation = 1).
// Result channel (out_valid/out_ready): at frame end one beat per channel,
// channel 0 first, out_last set on the final channel.
// Configuration channel (cfg_valid/cfg_ready): index 0 frame length,
// index 1 rounding mask; cfg_ready is always high.
// A sample is read, added and written back through the sum/count RAM; a
// tick that does not close a frame only advances the tick counter. No
// new beat is taken until the last one is done. A closing tick sweeps
// every channel, one at a time, through one bit-serial divider that
// retires one quotient bit per cycle over the 40-bit sum.
// Reset (synchronous, rst_n low) empties all channels, clears the tick
// counter and restores the configuration defaults; no clearing pass.
// If the receiver stalls, the sweep holds with the next result ready;
// once the final result is loaded the block takes new beats at once.
module multichannel_frame_averager #(
  parameter int NUM_CHANNELS = 16,
  parameter int FRAC_BITS    = 8
) (
  input  logic                                  clk,
  input  logic                                  rst_n,
  input  logic                                  in_valid,
  output logic                                  in_ready,
  input  logic                                  in_operation,
  input  logic [mfa_pkg::CH_W-1:0]              in_channel,
  input  logic signed [mfa_pkg::DATA_W-1:0]     in_sample_value,
  output logic                                  out_valid,
  input  logic                                  out_ready,
  output logic [mfa_pkg::CH_W-1:0]              out_channel,
  output logic signed [mfa_pkg::DATA_W-1:0]     out_average,
  output logic [mfa_pkg::CNT_W-1:0]             out_sample_count,
  output logic                                  out_has_value,
  output logic                                  out_last,
  input  logic                                  cfg_valid,
  output logic                                  cfg_ready,
  input  logic [mfa_pkg::CFG_IDX_W-1:0]         cfg_index,
  input  logic [mfa_pkg::CFG_DATA_W-1:0]        cfg_data
);

  import mfa_pkg::*;

  cmd_t cmd;
  sts_t sts;

  assign cfg_ready = 1'b1;

  mfa_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .sts      (sts),
    .cmd      (cmd)
  );

  mfa_dp #(
    .NUM_CHANNELS (NUM_CHANNELS),
    .FRAC_BITS    (FRAC_BITS)
  ) u_dp (
    .clk              (clk),
    .rst_n            (rst_n),
    .cmd              (cmd),
    .sts              (sts),
    .in_operation     (in_operation),
    .in_channel       (in_channel),
    .in_sample_value  (in_sample_value),
    .cfg_valid        (cfg_valid),
    .cfg_index        (cfg_index),
    .cfg_data         (cfg_data),
    .out_ready        (out_ready),
    .out_valid        (out_valid),
    .out_channel      (out_channel),
    .out_average      (out_average),
    .out_sample_count (out_sample_count),
    .out_has_value    (out_has_value),
    .out_last         (out_last)
  );

endmodule

[test/tb_multichannel_frame_averager.sv]
module tb_multichannel_frame_averager;
  timeunit 1ns;
  timeprecision 1ps;

  import mfa_pkg::*;

  localparam int NUM_CH      = 16;
  localparam int FRAC_BITS   = 8;
  localparam int BUSY_PCT    = 31;
  localparam int SETTLE      = 12;
  localparam int TAIL        = 64;
  localparam int STALL_LIMIT = 20000;

  // fixed-point helpers for the rounded channels
  localparam longint HALF_LSB = 64'sd1 <<< (FRAC_BITS - 1);
  localparam longint INT_TOP  = (64'sh7FFF_FFFF >>> FRAC_BITS) <<< FRAC_BITS;

  localparam logic signed [DATA_W-1:0] SAMPLE_MAX = 32'sh7FFF_FFFF;
  localparam logic signed [DATA_W-1:0] SAMPLE_MIN = 32'sh8000_0000;

  localparam logic [CFG_IDX_W-1:0] FIRST_UNUSED_IDX = CFG_ROUND_MASK + 1'b1;

  typedef struct packed {
    logic [CH_W-1:0]          chan;
    logic signed [DATA_W-1:0] average;
    logic [CNT_W-1:0]         count;
    logic                     has_value;
    logic                     last;
  } frame_result_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;

  logic                     in_valid = 1'b0;
  logic                     in_ready;
  logic                     in_operation = OP_SAMPLE;
  logic [CH_W-1:0]          in_channel = '0;
  logic signed [DATA_W-1:0] in_sample_value = '0;

  logic                     out_valid;
  logic                     out_ready = 1'b0;
  logic [CH_W-1:0]          out_channel;
  logic signed [DATA_W-1:0] out_average;
  logic [CNT_W-1:0]         out_sample_count;
  logic                     out_has_value;
  logic                     out_last;

  logic                     cfg_valid = 1'b0;
  logic                     cfg_ready;
  logic [CFG_IDX_W-1:0]     cfg_index = '0;
  logic [CFG_DATA_W-1:0]    cfg_data = '0;

  // predicted block state
  longint            chan_sum   [NUM_CH];
  logic [CNT_W-1:0]  chan_count [NUM_CH];
  logic [FLEN_W-1:0] tick_count;
  logic [FLEN_W-1:0] frame_len;
  logic [MASK_W-1:0] round_mask;

  frame_result_t pending_averages[$];
  int            mismatch_count = 0;
  int            idle_pct = BUSY_PCT;
  int            quiet_cycles = 0;

  multichannel_frame_averager #(
    .NUM_CHANNELS(NUM_CH),
    .FRAC_BITS   (FRAC_BITS)
  ) DUT (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_valid        (in_valid),
    .in_ready        (in_ready),
    .in_operation    (in_operation),
    .in_channel      (in_channel),
    .in_sample_value (in_sample_value),
    .out_valid       (out_valid),
    .out_ready       (out_ready),
    .out_channel     (out_channel),
    .out_average     (out_average),
    .out_sample_count(out_sample_count),
    .out_has_value   (out_has_value),
    .out_last        (out_last),
    .cfg_valid       (cfg_valid),
    .cfg_ready       (cfg_ready),
    .cfg_index       (cfg_index),
    .cfg_data        (cfg_data)
  );

  // 8 ns clock
  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  // half-up rounding to a whole number, saturating at the top integer
  function automatic longint round_to_integer(longint t);
    longint r;
    r = ((t + HALF_LSB) >>> FRAC_BITS) <<< FRAC_BITS;
    if (r > INT_TOP) r = INT_TOP;
    return r;
  endfunction

  function automatic logic signed [DATA_W-1:0] pick_sample();
    case ($urandom_range(7))
      0:       return SAMPLE_MAX;
      1:       return SAMPLE_MIN;
      2, 3:    return int'($urandom_range(4095)) - 2048;
      default: return $urandom;
    endcase
  endfunction

  task automatic clear_frame();
    for (int c = 0; c < NUM_CH; c++) begin
      chan_sum[c]   = 0;
      chan_count[c] = '0;
    end
    tick_count = '0;
  endtask

  // apply one accepted beat to the predicted state, queue any frame averages
  task automatic predict_beat(logic op, logic [CH_W-1:0] ch, logic signed [DATA_W-1:0] val);
    frame_result_t r;
    longint        mean;
    if (op == OP_SAMPLE) begin
      // saturated channels drop further samples
      if (int'(ch) < NUM_CH && chan_count[ch] != CNT_MAX) begin
        chan_sum[ch]   += longint'(val);
        chan_count[ch] += 1'b1;
      end
      return;
    end
    if (tick_count != TICK_MAX) tick_count += 1'b1;
    if (tick_count < frame_len) return;
    for (int c = 0; c < NUM_CH; c++) begin
      mean = 0;
      if (chan_count[c] != '0) begin
        mean = chan_sum[c] / longint'(chan_count[c]);
        if (round_mask[c]) mean = round_to_integer(mean);
      end
      r.chan      = CH_W'(c);
      r.average   = mean[DATA_W-1:0];
      r.count     = chan_count[c];
      r.has_value = (chan_count[c] != '0);
      r.last      = (c == NUM_CH - 1);
      pending_averages.push_back(r);
    end
    clear_frame();
  endtask

  task automatic report_mismatch(string what, int ch, longint got, longint want);
    $display("[%0t] mismatch on %s, channel %0d: got %0d, expected %0d",
             $realtime, what, ch, got, want);
    mismatch_count++;
  endtask

  // one input beat; valid is only dropped when the sender idles
  task automatic send_beat(logic op, logic [CH_W-1:0] ch, logic signed [DATA_W-1:0] val);
    while ($urandom_range(99) < idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid        <= 1'b1;
    in_operation    <= op;
    in_channel      <= ch;
    in_sample_value <= val;
    do @(posedge clk); while (!in_ready);
    predict_beat(op, ch, val);
  endtask

  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    do @(posedge clk); while (!cfg_ready);
    case (idx)
      CFG_FRAME_LENGTH: frame_len  = data[FLEN_W-1:0];
      CFG_ROUND_MASK:   round_mask = data[MASK_W-1:0];
      default: ;
    endcase
    cfg_valid <= 1'b0;
    @(posedge clk);
  endtask

  // hold the sender until every frame average is out, then let samples settle
  task automatic wait_for_results();
    in_valid <= 1'b0;
    while (pending_averages.size() != 0) @(posedge clk);
    repeat (SETTLE) @(posedge clk);
  endtask

  // default frame length and rounding mask straight out of reset
  task automatic test_reset_defaults();
    send_beat(OP_SAMPLE, 4'd13, 32'sh0000_0180);
    send_beat(OP_SAMPLE, 4'd13, 32'sh0000_0101);
    send_beat(OP_SAMPLE, 4'd12, 32'sh0000_0180);
    repeat (FRAME_LEN_RST) send_beat(OP_TICK, CH_W'($urandom), $urandom);
    wait_for_results();
  endtask

  // truncation, half-up rounding, rounding overflow, empty frame, zero length
  task automatic test_rounding_extremes();
    write_reg(CFG_FRAME_LENGTH, 16'd1);
    write_reg(CFG_ROUND_MASK, 16'h01C3);
    send_beat(OP_SAMPLE, 4'd0, SAMPLE_MAX);
    send_beat(OP_SAMPLE, 4'd1, SAMPLE_MIN);
    send_beat(OP_SAMPLE, 4'd2, SAMPLE_MAX);
    send_beat(OP_SAMPLE, 4'd3, SAMPLE_MIN);
    send_beat(OP_SAMPLE, 4'd4, 32'sd1);
    send_beat(OP_SAMPLE, 4'd4, -32'sd2);
    send_beat(OP_SAMPLE, 4'd5, -32'sd3);
    send_beat(OP_SAMPLE, 4'd5, 32'sd0);
    send_beat(OP_SAMPLE, 4'd6, 32'sh80);
    send_beat(OP_SAMPLE, 4'd7, -32'sh80);
    send_beat(OP_SAMPLE, 4'd8, -32'sh81);
    send_beat(OP_SAMPLE, 4'd15, -32'sd1);
    send_beat(OP_TICK, CH_W'($urandom), $urandom);
    wait_for_results();
    // a zero frame length behaves as one; every channel empty
    write_reg(CFG_FRAME_LENGTH, 16'd0);
    send_beat(OP_TICK, CH_W'($urandom), $urandom);
    wait_for_results();
  endtask

  // lowering the length below the current tick count ends the frame on the next tick
  task automatic test_frame_length_lowered();
    write_reg(CFG_FRAME_LENGTH, 16'd200);
    send_beat(OP_SAMPLE, 4'd9, pick_sample());
    repeat (3) send_beat(OP_TICK, CH_W'($urandom), $urandom);
    wait_for_results();
    write_reg(CFG_FRAME_LENGTH, 16'd2);
    send_beat(OP_TICK, CH_W'($urandom), $urandom);
    wait_for_results();
  endtask

  // one channel pushed past count saturation with the largest sample, no idling
  task automatic test_count_saturation();
    write_reg(CFG_FRAME_LENGTH, 16'd1);
    write_reg(CFG_ROUND_MASK, 16'hFFFF);
    idle_pct = 0;
    send_beat(OP_SAMPLE, 4'd7, pick_sample());
    send_beat(OP_SAMPLE, 4'd0, SAMPLE_MIN);
    for (int i = 0; i < 256; i++) send_beat(OP_SAMPLE, 4'd15, SAMPLE_MAX);
    idle_pct = BUSY_PCT;
    send_beat(OP_TICK, CH_W'($urandom), $urandom);
    wait_for_results();
  endtask

  // random samples and ticks over several settings
  task automatic test_random_frames();
    logic [FLEN_W-1:0] flen;
    logic [MASK_W-1:0] mask;
    for (int p = 0; p < 6; p++) begin
      wait_for_results();
      flen = (p == 0) ? 8'd1 : (p == 5) ? FLEN_W'($urandom_range(40, 9))
                                        : FLEN_W'($urandom_range(8, 2));
      mask = (p == 1) ? 16'h0000 : (p == 3) ? 16'hFFFF : MASK_W'($urandom);
      write_reg(CFG_FRAME_LENGTH, {8'($urandom), flen});
      write_reg(CFG_ROUND_MASK, mask);
      // writes to unmapped indexes must change nothing
      write_reg(CFG_IDX_W'($urandom_range(2 ** CFG_IDX_W - 1, FIRST_UNUSED_IDX)),
                CFG_DATA_W'($urandom));
      idle_pct = (p == 2) ? 0 : BUSY_PCT;
      for (int i = 0; i < 14; i++) begin
        if (p == 4 && i == 7) wait_for_results();
        if ($urandom_range(3) == 0) send_beat(OP_TICK, CH_W'($urandom), $urandom);
        else send_beat(OP_SAMPLE, CH_W'($urandom), pick_sample());
      end
    end
    idle_pct = BUSY_PCT;
  endtask

  // receiver stalls at random
  always @(posedge clk) out_ready <= ($urandom_range(99) >= idle_pct);

  // compare each result beat with the oldest prediction
  always @(posedge clk) begin
    frame_result_t want;
    if (rst_n && out_valid && out_ready) begin
      if (pending_averages.size() == 0) begin
        report_mismatch("unexpected beat", out_channel, out_average, 0);
      end else begin
        want = pending_averages.pop_front();
        if (out_channel !== want.chan)
          report_mismatch("out_channel", want.chan, out_channel, want.chan);
        if (out_average !== want.average)
          report_mismatch("out_average", want.chan, out_average, $signed(want.average));
        if (out_sample_count !== want.count)
          report_mismatch("out_sample_count", want.chan, out_sample_count, want.count);
        if (out_has_value !== want.has_value)
          report_mismatch("out_has_value", want.chan, out_has_value, want.has_value);
        if (out_last !== want.last)
          report_mismatch("out_last", want.chan, out_last, want.last);
      end
    end
  end

  // watchdog on cycles with no beat on any channel
  always @(posedge clk) begin
    if (!rst_n || (in_valid && in_ready) || (out_valid && out_ready) ||
        (cfg_valid && cfg_ready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= STALL_LIMIT) begin
      $display("Verification failed");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  initial begin
    frame_len  = FRAME_LEN_RST;
    round_mask = ROUND_MASK_RST;
    clear_frame();
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_reset_defaults();
    test_rounding_extremes();
    test_frame_length_lowered();
    test_count_saturation();
    test_random_frames();

    wait_for_results();
    repeat (TAIL) @(posedge clk);
    if (pending_averages.size() != 0)
      report_mismatch("missing beats", pending_averages[0].chan,
                      0, pending_averages.size());
    if (mismatch_count == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule

[multichannel_frame_averager.f]
rtl/mfa_pkg.sv
rtl/mfa_ram.sv
rtl/mfa_div.sv
rtl/mfa_dp.sv
rtl/mfa_ctrl.sv
rtl/multichannel_frame_averager.sv
test/tb_multichannel_frame_averager.sv
